@@ hw/rtl/bfla_pkg.sv @@
// ----------------------------------------------------------------------------
// bfla_pkg
// Shared types and constants of the multi-precision Fibonacci limb adder.
// ----------------------------------------------------------------------------
package bfla_pkg;

  // limb count and field widths
  localparam int NumLimbs = 25;
  localparam int LimbW    = 30;
  localparam int IndexW   = 10;
  localparam int PosW     = 5;
  localparam int LimbIdxW = (NumLimbs > 1) ? $clog2(NumLimbs) : 1;

  // decimal limb base, one bit wider than a limb to hold a raw sum
  localparam logic [LimbW:0] LimbBase = (LimbW + 1)'(1000000000);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic clear;     // load the start terms
    logic seed_one;  // start term F(1) = 1 goes into limb 0
    logic shift;     // move newer terms one cell up for readout
  } cell_ctrl_t;

endpackage

@@ hw/rtl/big_fibonacci_limb_adder.sv @@
// ----------------------------------------------------------------------------
// big_fibonacci_limb_adder
// Computes F(n) as base 10^9 limbs on a chain of limb cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / index_i) takes one word, the
//   Fibonacci index n. The output channel (out_valid_o / out_ready_i) returns
//   NumLimbs words, most significant limb first, each with limb_value_o,
//   limb_position_o and last_limb_o, which is set on limb 0.
//   One cell per limb adds its older and newer term with the carry handed up
//   from the cell below; steps enter the chain one per cycle, skewed through
//   the registered step token and carry of each cell. After the accepting
//   cycle the sequencer issues the addition steps (none for n < 2), then lets
//   the chain drain; readout then shifts the limbs up the chain, one word per
//   cycle when the receiver keeps up, each word loaded from the top cell.
//   The n - 1 addition steps plus the chain skew set the compute time, the
//   single output register the readout rate. One index is worked on at a
//   time: in_ready_o is high only while idle. A stalled receiver holds the
//   output word and freezes the readout. Reset returns the sequencer to idle
//   with no word pending; the limb stores are reloaded at every request.
// ----------------------------------------------------------------------------
module big_fibonacci_limb_adder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bfla_pkg::IndexW-1:0]      index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bfla_pkg::LimbW-1:0]       limb_value_o,
  output logic [bfla_pkg::PosW-1:0]        limb_position_o,
  output logic                             last_limb_o
);

  bfla_pkg::cell_ctrl_t             cell_ctrl;
  logic                             issue;
  logic [bfla_pkg::NumLimbs:0]      en_chain;
  logic [bfla_pkg::NumLimbs:0]      carry_chain;
  logic [bfla_pkg::LimbW-1:0]       newer [bfla_pkg::NumLimbs+1];

  // chain inputs at limb 0
  assign en_chain[0]    = issue;
  assign carry_chain[0] = 1'b0;
  assign newer[0]       = '0;

  // sequencer and output word
  bfla_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .index_i         (index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .limb_value_o    (limb_value_o),
    .limb_position_o (limb_position_o),
    .last_limb_o     (last_limb_o),
    .cell_ctrl_o     (cell_ctrl),
    .issue_o         (issue),
    .top_limb_i      (newer[bfla_pkg::NumLimbs])
  );

  // row of limb cells, limb 0 at the bottom
  for (genvar k = 0; k < bfla_pkg::NumLimbs; k++) begin : g_cell
    bfla_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .seed_i     (k == 0),
      .en_i       (en_chain[k]),
      .carry_i    (carry_chain[k]),
      .shift_in_i (newer[k]),
      .en_o       (en_chain[k+1]),
      .carry_o    (carry_chain[k+1]),
      .newer_o    (newer[k+1])
    );
  end

endmodule

@@ hw/rtl/bfla_cell.sv @@
// ----------------------------------------------------------------------------
// bfla_cell
// One limb of the chain: holds the older and newer term limbs, adds them with
// the carry from the cell below and hands its carry to the cell above.
// ----------------------------------------------------------------------------
module bfla_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bfla_pkg::cell_ctrl_t             ctrl_i,
  input  logic                             seed_i,
  input  logic                             en_i,
  input  logic                             carry_i,
  input  logic [bfla_pkg::LimbW-1:0]       shift_in_i,
  output logic                             en_o,
  output logic                             carry_o,
  output logic [bfla_pkg::LimbW-1:0]       newer_o
);

  logic [bfla_pkg::LimbW-1:0] older_q, older_d;
  logic [bfla_pkg::LimbW-1:0] newer_q, newer_d;
  logic                       carry_q, carry_d;
  logic                       en_q, en_d;
  logic [bfla_pkg::LimbW:0]   sum;
  logic [bfla_pkg::LimbW:0]   sum_mod;
  logic                       wrap;

  // limb add with decimal carry
  always_comb begin
    sum     = {1'b0, older_q} + {1'b0, newer_q} + (bfla_pkg::LimbW + 1)'(carry_i);
    wrap    = (sum >= bfla_pkg::LimbBase);
    sum_mod = wrap ? (sum - bfla_pkg::LimbBase) : sum;
  end

  // next term values
  always_comb begin
    older_d = older_q;
    newer_d = newer_q;
    carry_d = 1'b0;
    en_d    = 1'b0;
    if (ctrl_i.clear) begin
      older_d = '0;
      newer_d = bfla_pkg::LimbW'(seed_i & ctrl_i.seed_one);
    end else if (ctrl_i.shift) begin
      newer_d = shift_in_i;
    end else if (en_i) begin
      older_d = newer_q;
      newer_d = sum_mod[bfla_pkg::LimbW-1:0];
      carry_d = wrap;
      en_d    = 1'b1;
    end
  end

  // term limbs
  always_ff @(posedge clk_i) begin
    older_q <= older_d;
    newer_q <= newer_d;
  end

  // carry and step token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
      en_q    <= 1'b0;
    end else begin
      carry_q <= carry_d;
      en_q    <= en_d;
    end
  end

  assign en_o    = en_q;
  assign carry_o = carry_q;
  assign newer_o = newer_q;

endmodule

@@ hw/rtl/bfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfla_ctrl
// Sequencer of the limb chain: takes the index, issues the addition steps,
// waits for the chain to settle and reads the limbs out into the output word.
// ----------------------------------------------------------------------------
module bfla_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bfla_pkg::IndexW-1:0]      index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bfla_pkg::LimbW-1:0]       limb_value_o,
  output logic [bfla_pkg::PosW-1:0]        limb_position_o,
  output logic                             last_limb_o,
  output bfla_pkg::cell_ctrl_t             cell_ctrl_o,
  output logic                             issue_o,
  input  logic [bfla_pkg::LimbW-1:0]       top_limb_i
);

  bfla_pkg::state_e                  state_q, state_d;
  logic [bfla_pkg::IndexW-1:0]       steps_q, steps_d;
  logic [bfla_pkg::IndexW-1:0]       issue_cnt_q, issue_cnt_d;
  logic [bfla_pkg::LimbIdxW-1:0]     limb_cnt_q, limb_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [bfla_pkg::LimbW-1:0]        value_q, value_d;
  logic [bfla_pkg::PosW-1:0]         pos_q, pos_d;
  logic                              last_q, last_d;
  logic                              accept;
  logic                              emit;
  logic                              run_done;
  logic                              drain_done;

  assign accept     = in_valid_i && (state_q == bfla_pkg::ST_IDLE);
  assign emit       = (state_q == bfla_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);
  assign run_done   = (issue_cnt_q == (steps_q - bfla_pkg::IndexW'(1)));
  assign drain_done = (limb_cnt_q == bfla_pkg::LimbIdxW'(bfla_pkg::NumLimbs - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfla_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (index_i >= bfla_pkg::IndexW'(2)) ? bfla_pkg::ST_RUN
                                                      : bfla_pkg::ST_DRAIN;
        end
      end
      bfla_pkg::ST_RUN: begin
        if (run_done) begin
          state_d = bfla_pkg::ST_DRAIN;
        end
      end
      bfla_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_d = bfla_pkg::ST_EMIT;
        end
      end
      bfla_pkg::ST_EMIT: begin
        if (emit && (limb_cnt_q == '0)) begin
          state_d = bfla_pkg::ST_IDLE;
        end
      end
      default: state_d = bfla_pkg::ST_IDLE;
    endcase
  end

  // outputs, counters and output word
  always_comb begin
    in_ready_o           = (state_q == bfla_pkg::ST_IDLE);
    cell_ctrl_o.clear    = accept;
    cell_ctrl_o.seed_one = (index_i != '0);
    cell_ctrl_o.shift    = emit;
    issue_o              = (state_q == bfla_pkg::ST_RUN);
    steps_d              = steps_q;
    issue_cnt_d          = issue_cnt_q;
    limb_cnt_d           = limb_cnt_q;
    out_valid_d          = out_valid_q && !out_ready_i;
    value_d              = value_q;
    pos_d                = pos_q;
    last_d               = last_q;
    unique case (state_q)
      bfla_pkg::ST_IDLE: begin
        if (accept) begin
          steps_d     = index_i - bfla_pkg::IndexW'(1);
          issue_cnt_d = '0;
          limb_cnt_d  = '0;
        end
      end
      bfla_pkg::ST_RUN: begin
        issue_cnt_d = issue_cnt_q + bfla_pkg::IndexW'(1);
      end
      bfla_pkg::ST_DRAIN: begin
        limb_cnt_d = drain_done ? limb_cnt_q : limb_cnt_q + bfla_pkg::LimbIdxW'(1);
      end
      bfla_pkg::ST_EMIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          value_d     = top_limb_i;
          pos_d       = bfla_pkg::PosW'(limb_cnt_q);
          last_d      = (limb_cnt_q == '0);
          limb_cnt_d  = limb_cnt_q - bfla_pkg::LimbIdxW'(1);
        end
      end
      default: begin
        issue_cnt_d = issue_cnt_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfla_pkg::ST_IDLE;
      steps_q     <= '0;
      issue_cnt_q <= '0;
      limb_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      issue_cnt_q <= issue_cnt_d;
      limb_cnt_q  <= limb_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
    last_q  <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign limb_value_o    = value_q;
  assign limb_position_o = pos_q;
  assign last_limb_o     = last_q;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the multi-precision Fibonacci limb adder. Each index word is
// turned into the expected limb words by a local base 10^9 model. These are
// queued in order and checked field by field as the block returns them. A
// short table of corner indices comes first, then random indices, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  // one expected output word
  typedef struct packed {
    logic [bfla_pkg::LimbW-1:0] value;
    logic [bfla_pkg::PosW-1:0]  position;
    logic                       last;
  } limb_word_t;

  // directed row: index, and a low limb value where it is known by eye
  typedef struct packed {
    logic [bfla_pkg::IndexW-1:0] index;
    logic                        known;
    logic [bfla_pkg::LimbW-1:0]  low_limb;
  } index_row_t;

  localparam logic [bfla_pkg::LimbW:0] DecimalBase = 31'd1000000000;
  localparam int RandomIndices = 80;
  localparam int QuietTail     = 20;
  localparam int LongHoldOff   = 2000;
  localparam int DrainCycles   = 60;

  localparam index_row_t DirectedRows [19] = '{
    '{10'd0,    1'b1, 30'd0},
    '{10'd1,    1'b1, 30'd1},
    '{10'd2,    1'b1, 30'd1},
    '{10'd3,    1'b1, 30'd2},
    '{10'd4,    1'b1, 30'd3},
    '{10'd5,    1'b1, 30'd5},
    '{10'd1023, 1'b0, 30'd0},
    '{10'd0,    1'b1, 30'd0},
    '{10'd1022, 1'b0, 30'd0},
    '{10'd1,    1'b1, 30'd1},
    '{10'd512,  1'b0, 30'd0},
    '{10'd511,  1'b0, 30'd0},
    '{10'h2AA,  1'b0, 30'd0},
    '{10'h155,  1'b0, 30'd0},
    '{10'd44,   1'b0, 30'd0},
    '{10'd45,   1'b0, 30'd0},
    '{10'd46,   1'b0, 30'd0},
    '{10'd100,  1'b0, 30'd0},
    '{10'd6,    1'b1, 30'd8}
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [bfla_pkg::IndexW-1:0]   index_i     = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [bfla_pkg::LimbW-1:0]    limb_value_o;
  logic [bfla_pkg::PosW-1:0]     limb_position_o;
  logic                          last_limb_o;

  limb_word_t expected_limbs_q [$];
  int         mismatch_count = 0;
  bit         idling_on      = 1'b1;
  bit         hold_off_req   = 1'b0;

  big_fibonacci_limb_adder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .index_i         (index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .limb_value_o    (limb_value_o),
    .limb_position_o (limb_position_o),
    .last_limb_o     (last_limb_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // F(n) in base 10^9 limbs, top carry dropped, queued most significant first
  task automatic queue_fibonacci(input logic [bfla_pkg::IndexW-1:0] n);
    logic [bfla_pkg::LimbW-1:0] older [bfla_pkg::NumLimbs];
    logic [bfla_pkg::LimbW-1:0] newer [bfla_pkg::NumLimbs];
    logic [bfla_pkg::LimbW-1:0] total [bfla_pkg::NumLimbs];
    logic [bfla_pkg::LimbW:0]   acc;
    logic                       carry;
    limb_word_t                 w;
    for (int k = 0; k < bfla_pkg::NumLimbs; k++) begin
      older[k] = '0;
      newer[k] = '0;
    end
    newer[0] = bfla_pkg::LimbW'(1);
    for (int i = 2; i <= int'(n); i++) begin
      carry = 1'b0;
      for (int k = 0; k < bfla_pkg::NumLimbs; k++) begin
        acc = {1'b0, older[k]} + {1'b0, newer[k]} + (bfla_pkg::LimbW + 1)'(carry);
        if (acc >= DecimalBase) begin
          total[k] = bfla_pkg::LimbW'(acc - DecimalBase);
          carry    = 1'b1;
        end else begin
          total[k] = acc[bfla_pkg::LimbW-1:0];
          carry    = 1'b0;
        end
      end
      for (int k = 0; k < bfla_pkg::NumLimbs; k++) begin
        older[k] = newer[k];
        newer[k] = total[k];
      end
    end
    for (int k = bfla_pkg::NumLimbs - 1; k >= 0; k--) begin
      w.value    = (n == 0) ? older[k] : newer[k];
      w.position = bfla_pkg::PosW'(k);
      w.last     = (k == 0);
      expected_limbs_q.push_back(w);
    end
  endtask

  // offer one index word, with an optional gap first, until it is taken
  task automatic offer_index(input logic [bfla_pkg::IndexW-1:0] n);
    if (idling_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    index_i    <= n;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sender: reset, directed table, pause, random indices, drain
  initial begin
    limb_word_t                  w;
    logic [bfla_pkg::IndexW-1:0] n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[r]) begin
      offer_index(DirectedRows[r].index);
      if (DirectedRows[r].known) begin
        for (int k = bfla_pkg::NumLimbs - 1; k >= 0; k--) begin
          w.value    = (k == 0) ? DirectedRows[r].low_limb : '0;
          w.position = bfla_pkg::PosW'(k);
          w.last     = (k == 0);
          expected_limbs_q.push_back(w);
        end
      end else begin
        queue_fibonacci(DirectedRows[r].index);
      end
    end

    // sender pause until every limb is back
    in_valid_i <= 1'b0;
    while (expected_limbs_q.size() != 0) @(posedge clk_i);
    hold_off_req = 1'b1;

    // random indices, many small ones to keep the run short
    for (int i = 0; i < RandomIndices; i++) begin
      if (i >= RandomIndices - QuietTail) idling_on = 1'b0;
      if ($urandom_range(0, 9) < 3) n = bfla_pkg::IndexW'($urandom_range(0, 60));
      else                          n = bfla_pkg::IndexW'($urandom_range(0, 1023));
      offer_index(n);
      queue_fibonacci(n);
    end

    in_valid_i <= 1'b0;
    while (expected_limbs_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: one long hold-off on request, random stalls, none in the tail
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LongHoldOff) @(posedge clk_i);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // check each accepted limb word against the oldest expectation
  always @(posedge clk_i) begin
    limb_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_limbs_q.size() == 0) begin
        $error("limb word with none expected: value %0d position %0d last %0b",
               limb_value_o, limb_position_o, last_limb_o);
        mismatch_count++;
      end else begin
        want = expected_limbs_q.pop_front();
        if (limb_value_o !== want.value) begin
          $error("limb_value: expected %0d, actual %0d", want.value, limb_value_o);
          mismatch_count++;
        end
        if (limb_position_o !== want.position) begin
          $error("limb_position: expected %0d, actual %0d", want.position,
                 limb_position_o);
          mismatch_count++;
        end
        if (last_limb_o !== want.last) begin
          $error("last_limb: expected %0b, actual %0b", want.last, last_limb_o);
          mismatch_count++;
        end
      end
    end
  end

endmodule
